[hdl/nvpt_pkg.sv]
// shared constants and types for the node value pool table
package nvpt_pkg;

    localparam int MODE_W    = 3;
    localparam int KEY_W     = 8;
    localparam int VAL_W     = 16;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEC    = 3'd4;

    // write enables for the key and value memories
    typedef struct packed {
        logic key_we;
        logic val_we;
    } nvpt_wr_t;

endpackage

[hdl/nvpt_if.sv]
// request, response and configuration channel interfaces
interface nvpt_req_if;
    import nvpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  node_addr;
    logic [VAL_W-1:0]  data_value;
    modport source (output valid, output mode, output node_addr, output data_value,
                    input ready);
    modport sink (input valid, input mode, input node_addr, input data_value,
                  output ready);
endinterface

interface nvpt_rsp_if;
    import nvpt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 success;
    logic [VAL_W-1:0]     found_value;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT_OUT_W-1:0] entry_count;
    modport source (output valid, output success, output found_value, output entry_index,
                    output entry_count, input ready);
    modport sink (input valid, input success, input found_value, input entry_index,
                  input entry_count, output ready);
endinterface

interface nvpt_cfg_if;
    import nvpt_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] age_limit;
    modport source (output valid, output age_limit, input ready);
    modport sink (input valid, input age_limit, output ready);
endinterface

[hdl/nvpt_store.sv]
// key and value memories, one write port each, shared read address with registered read data
module nvpt_store #(
    parameter int POOL_DEPTH = 16,
    parameter int IW         = 4
) (
    input  logic                      clk,
    input  nvpt_pkg::nvpt_wr_t        wr,
    input  logic [IW-1:0]             wr_addr,
    input  logic [nvpt_pkg::KEY_W-1:0] wr_key,
    input  logic [nvpt_pkg::VAL_W-1:0] wr_val,
    input  logic [IW-1:0]             rd_addr,
    output logic [nvpt_pkg::KEY_W-1:0] rd_key,
    output logic [nvpt_pkg::VAL_W-1:0] rd_val
);
    import nvpt_pkg::*;

    logic [KEY_W-1:0] key_mem [POOL_DEPTH];
    logic [VAL_W-1:0] val_mem [POOL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr.val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        rd_key <= key_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

endmodule

[hdl/nvpt_ctrl.sv]
// request sequencer: slot scan, ageing pass and response register
module nvpt_ctrl #(
    parameter int POOL_DEPTH = 16,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    nvpt_req_if.sink                   req,
    nvpt_rsp_if.source                 rsp,
    input  logic [nvpt_pkg::VAL_W-1:0] age_limit,
    output nvpt_pkg::nvpt_wr_t         wr,
    output logic [IW-1:0]              wr_addr,
    output logic [nvpt_pkg::KEY_W-1:0] wr_key,
    output logic [nvpt_pkg::VAL_W-1:0] wr_val,
    output logic [IW-1:0]              rd_addr,
    input  logic [nvpt_pkg::KEY_W-1:0] rd_key,
    input  logic [nvpt_pkg::VAL_W-1:0] rd_val
);
    import nvpt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DEC, ST_DONE} state_t;

    state_t               state_reg;
    logic [MODE_W-1:0]    op_reg;
    logic [KEY_W-1:0]     addr_reg;
    logic [VAL_W-1:0]     data_reg;
    logic [IW-1:0]        ptr_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 res_ok_reg;
    logic [VAL_W-1:0]     res_val_reg;
    logic [IW-1:0]        res_idx_reg;
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [VAL_W-1:0]     out_val_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic          accept;
    logic          last;
    logic          full;
    logic          key_hit;
    logic          load_out;
    logic [IW-1:0] ptr_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign ptr_inc   = ptr_reg + IW'(1);
    assign last      = (CW'(ptr_reg) + CW'(1)) == cnt_reg;
    assign full      = cnt_reg == CW'(POOL_DEPTH);
    assign key_hit   = rd_key == addr_reg;
    // response register is free or being emptied this cycle
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = out_ok_reg;
    assign rsp.found_value = out_val_reg;
    assign rsp.entry_index = out_idx_reg;
    assign rsp.entry_count = out_cnt_reg;

    // read data for rd_addr shows up in the next cycle, matching ptr_reg
    always_comb
    begin
        rd_addr = (state_reg == ST_IDLE) ? '0 : ptr_inc;
    end

    always_comb
    begin
        wr      = '0;
        wr_addr = ptr_reg;
        wr_key  = addr_reg;
        wr_val  = data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // add into an empty table needs no scan
                if (accept && req.mode == MODE_ADD && cnt_reg == '0)
                begin
                    wr.key_we = 1'b1;
                    wr.val_we = 1'b1;
                    wr_addr   = '0;
                    wr_key    = req.node_addr;
                    wr_val    = req.data_value;
                end
            end
            ST_SCAN:
            begin
                if (key_hit)
                begin
                    wr.val_we = (op_reg == MODE_UPDATE);
                end
                else if (last && op_reg == MODE_ADD)
                begin
                    wr.key_we = 1'b1;
                    wr.val_we = 1'b1;
                    wr_addr   = cnt_reg[IW-1:0];
                end
            end
            ST_DEC:
            begin
                if (rd_val > age_limit)
                begin
                    wr.val_we = 1'b1;
                    wr_val    = rd_val - VAL_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= MODE_CLEAR;
            addr_reg      <= '0;
            data_reg      <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            res_ok_reg    <= 1'b0;
            res_val_reg   <= '0;
            res_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_val_reg   <= '0;
            out_idx_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= req.mode;
                        addr_reg    <= req.node_addr;
                        data_reg    <= req.data_value;
                        ptr_reg     <= '0;
                        res_ok_reg  <= 1'b0;
                        res_val_reg <= '0;
                        res_idx_reg <= '0;
                        unique case (req.mode)
                            MODE_CLEAR:
                            begin
                                cnt_reg    <= '0;
                                res_ok_reg <= 1'b1;
                                state_reg  <= ST_DONE;
                            end
                            MODE_LOOKUP, MODE_UPDATE:
                            begin
                                state_reg <= (cnt_reg == '0) ? ST_DONE : ST_SCAN;
                            end
                            MODE_ADD:
                            begin
                                if (full)
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else if (cnt_reg == '0)
                                begin
                                    cnt_reg    <= CW'(1);
                                    res_ok_reg <= 1'b1;
                                    state_reg  <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            MODE_DEC:
                            begin
                                res_ok_reg <= 1'b1;
                                state_reg  <= (cnt_reg == '0) ? ST_DONE : ST_DEC;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (key_hit)
                    begin
                        // first match wins; a hit on add is a failure
                        if (op_reg != MODE_ADD)
                        begin
                            res_ok_reg  <= 1'b1;
                            res_idx_reg <= ptr_reg;
                            if (op_reg == MODE_LOOKUP)
                            begin
                                res_val_reg <= rd_val;
                            end
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (last)
                    begin
                        if (op_reg == MODE_ADD)
                        begin
                            cnt_reg     <= cnt_reg + CW'(1);
                            res_ok_reg  <= 1'b1;
                            res_idx_reg <= cnt_reg[IW-1:0];
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                    end
                end
                ST_DEC:
                begin
                    if (last)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_inc;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        out_ok_reg  <= res_ok_reg;
                        out_val_reg <= res_val_reg;
                        out_idx_reg <= IDX_OUT_W'(res_idx_reg);
                        out_cnt_reg <= CNT_OUT_W'(cnt_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(POOL_DEPTH))
        else $error("entry count above pool depth");

    a_key_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr.key_we |=> cnt_reg == CW'($past(wr_addr)) + CW'(1))
        else $error("key written without appending at the end of the table");

    a_dec_only_above: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.val_we && state_reg == ST_DEC) |-> rd_val > age_limit)
        else $error("ageing lowered a value at or below the age limit");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr.key_we |-> !full)
        else $error("key written into a full table");
`endif

endmodule

[hdl/node_value_pool_table_top.sv]
// node value pool table: top level with age limit register
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    mode, node_addr, data_value
//  rsp      out  valid / ready    success, found_value, entry_index, entry_count
//  cfg      in   valid / ready    age_limit
//
// one request at a time; clear and unused modes go straight to the response step, the others
// scan up to entry_count slots, one slot per cycle through the shared memory read port
// a finished response waits in the output register while the next request is taken
// a request that finishes while that response is still held stalls until it is taken
// reset empties the table at once; memory contents are left as they are
module node_value_pool_table_top #(
    parameter int POOL_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    nvpt_req_if.sink   req,
    nvpt_rsp_if.source rsp,
    nvpt_cfg_if.sink   cfg
);
    import nvpt_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic [VAL_W-1:0] age_limit_reg;
    nvpt_wr_t         wr;
    logic [IW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;
    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            age_limit_reg <= cfg.age_limit;
        end
    end

    nvpt_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .age_limit (age_limit_reg),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_val    (wr_val),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_val    (rd_val)
    );

    nvpt_store #(
        .POOL_DEPTH (POOL_DEPTH),
        .IW         (IW)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_val  (wr_val),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val)
    );

endmodule
